// ===== rtl/core/bda_pkg.sv =====
`timescale 1ns / 1ps

package bda_pkg;

   // Field widths
   localparam int VALUE_W = 31;
   localparam int DIGIT_W = 6;
   localparam int BCD_W   = 4;

   // Default and upper bound of the digit count
   localparam int DEF_MAX_DIGITS = 10;

   // ASCII code of '0'
   localparam logic [DIGIT_W-1:0] ASCII_ZERO = 6'd48;

   // Divide by ten as multiply by ceil(2^35 / 10), exact for any 32-bit operand
   localparam int RECIP_W     = 32;
   localparam logic [RECIP_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT = 35;
   localparam int PROD_W      = VALUE_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

   // Controller states
   typedef enum logic [1:0] {
      BDA_IDLE,
      BDA_CONVERT,
      BDA_EMIT
   } bda_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic convert;
      logic advance;
   } bda_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic conv_done;
      logic last_digit;
   } bda_stat_type;

endpackage

// ===== rtl/core/bda_channels.sv =====
`timescale 1ns / 1ps

// Input channel: one binary value per transaction
interface bda_req_if;
   logic                        valid;
   logic                        ready;
   logic [bda_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

// Result channel: one ASCII digit per transaction
interface bda_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bda_pkg::DIGIT_W-1:0] digit_char;
   logic                        last;

   modport source (output valid, output digit_char, output last, input ready);
   modport sink (input valid, input digit_char, input last, output ready);
endinterface

// ===== rtl/core/bda_ctrl.sv =====
`timescale 1ns / 1ps

module bda_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  bda_pkg::bda_stat_type stat,
   output bda_pkg::bda_cmd_type  cmd
);

   bda_pkg::bda_state_type state_ff;
   bda_pkg::bda_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bda_pkg::BDA_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.load    = 1'b0;
      cmd.convert = 1'b0;
      cmd.advance = 1'b0;
      unique case (state_ff)
         bda_pkg::BDA_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = bda_pkg::BDA_CONVERT;
            end
         end
         bda_pkg::BDA_CONVERT: begin
            cmd.convert = 1'b1;
            if (stat.conv_done) begin
               state_in = bda_pkg::BDA_EMIT;
            end
         end
         bda_pkg::BDA_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.advance = 1'b1;
               if (stat.last_digit) begin
                  state_in = bda_pkg::BDA_IDLE;
               end
            end
         end
         default: begin
            state_in = bda_pkg::BDA_IDLE;
         end
      endcase
   end

   // Accepted value always starts a conversion
   a_load_to_convert: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == bda_pkg::BDA_CONVERT))
      else $error("accepted value did not start conversion");

   // Final divide step hands over to readout
   a_convert_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bda_pkg::BDA_CONVERT && stat.conv_done)
      |=> (state_ff == bda_pkg::BDA_EMIT))
      else $error("conversion end did not start readout");

   // Taking the last digit frees the block
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && stat.last_digit) |=> (state_ff == bda_pkg::BDA_IDLE))
      else $error("block busy after last digit");

endmodule

// ===== rtl/core/bda_datapath.sv =====
`timescale 1ns / 1ps

module bda_datapath #(
   parameter int MAX_DIGITS = bda_pkg::DEF_MAX_DIGITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bda_pkg::bda_cmd_type        cmd,
   input  logic [bda_pkg::VALUE_W-1:0] req_value,
   output bda_pkg::bda_stat_type       stat,
   output logic [bda_pkg::DIGIT_W-1:0] digit_char,
   output logic                        last
);

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);

   logic [bda_pkg::VALUE_W-1:0] value_ff;
   logic [IDX_W-1:0]            idx_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [IDX_W-1:0]            ptr_ff;
   logic [bda_pkg::BCD_W-1:0]   digit_ff [MAX_DIGITS];

   logic [bda_pkg::PROD_W-1:0]  prod;
   logic [bda_pkg::QUOT_W-1:0]  quot;
   logic [bda_pkg::VALUE_W-1:0] quot_x10;
   logic [bda_pkg::VALUE_W-1:0] diff;
   logic [bda_pkg::BCD_W-1:0]   rem;
   logic [CNT_W-1:0]            cnt_in;

   // Divide by ten: reciprocal multiply, remainder from q*10 by shift-add
   assign prod     = bda_pkg::PROD_W'(value_ff) * bda_pkg::PROD_W'(bda_pkg::RECIP_TEN);
   assign quot     = prod[bda_pkg::PROD_W-1:bda_pkg::RECIP_SHIFT];
   assign quot_x10 = bda_pkg::VALUE_W'({quot, 3'b000}) + bda_pkg::VALUE_W'({quot, 1'b0});
   assign diff     = value_ff - quot_x10;
   assign rem      = diff[bda_pkg::BCD_W-1:0];

   // Digit count tracks the highest nonzero digit, at least one
   assign cnt_in = (rem != '0) ? (CNT_W'(idx_ff) + CNT_W'(1)) : cnt_ff;

   assign stat.conv_done  = (quot == '0) || (idx_ff == IDX_W'(MAX_DIGITS - 1));
   assign stat.last_digit = (ptr_ff == '0);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         cnt_ff <= CNT_W'(1);
         ptr_ff <= '0;
      end else begin
         priority if (cmd.load) begin
            idx_ff <= '0;
            cnt_ff <= CNT_W'(1);
         end else if (cmd.convert) begin
            idx_ff <= idx_ff + IDX_W'(1);
            cnt_ff <= cnt_in;
            if (stat.conv_done) begin
               ptr_ff <= IDX_W'(cnt_in - CNT_W'(1));
            end
         end else if (cmd.advance) begin
            ptr_ff <= ptr_ff - IDX_W'(1);
         end
      end
   end

   // Working value and digit buffer, least significant digit at entry 0
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff <= req_value;
      end else if (cmd.convert) begin
         value_ff         <= bda_pkg::VALUE_W'(quot);
         digit_ff[idx_ff] <= rem;
      end
   end

   // Readout, most significant digit first
   assign digit_char = bda_pkg::ASCII_ZERO + bda_pkg::DIGIT_W'(digit_ff[ptr_ff]);
   assign last       = stat.last_digit;

   // Digit index steps by one while conversion continues
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.convert && !stat.conv_done) |=> (idx_ff == $past(idx_ff) + IDX_W'(1)))
      else $error("digit index did not advance");

   // Readout starts at the top digit of the count
   a_ptr_start: assert property (@(posedge clock) disable iff (reset)
      (cmd.convert && stat.conv_done) |=> (CNT_W'(ptr_ff) + CNT_W'(1) == cnt_ff))
      else $error("readout pointer does not match digit count");

   // No leading zero unless the value is a single digit
   a_no_lead_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.convert && stat.conv_done)
      |=> (cnt_ff == CNT_W'(1) || digit_ff[ptr_ff] != '0))
      else $error("leading zero digit emitted");

endmodule

// ===== rtl/core/binary_to_decimal_ascii_unit.sv =====
`timescale 1ns / 1ps

// Binary to decimal ASCII converter.
// req_bus carries one non-negative 31-bit value per transaction. rsp_bus returns
// its decimal digits as ASCII '0'..'9', most significant first, without leading
// zeros; last marks the final digit. Zero yields the single digit '0'. Only the
// low MAX_DIGITS decimal digits are kept.
// Timing: after a value is taken, one divide-by-ten step runs per cycle until the
// quotient is zero or MAX_DIGITS digits are formed, then the n digits leave one
// per cycle while the receiver is ready. No new value is taken while an item is
// in progress; the next value is taken in the cycle after the last digit
// leaves. The rate is set by the single reciprocal-multiply divider, which yields
// one digit per cycle, followed by readout of the digit buffer.
// req_bus.ready is high only while the block holds no item.
// Reset (synchronous) abandons any item in progress and returns to idle.
// If the receiver stalls, the current digit is held on rsp_bus unchanged and the
// block waits; no digit is lost or repeated.
module binary_to_decimal_ascii_unit #(
   parameter int MAX_DIGITS = bda_pkg::DEF_MAX_DIGITS
) (
   input logic clock,
   input logic reset,
   bda_req_if.sink   req_bus,
   bda_rsp_if.source rsp_bus
);

   bda_pkg::bda_cmd_type  cmd;
   bda_pkg::bda_stat_type stat;

   // Sequencer
   bda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Divider and digit buffer
   bda_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_value  (req_bus.value),
      .stat       (stat),
      .digit_char (rsp_bus.digit_char),
      .last       (rsp_bus.last)
   );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

   // Expected digit stream of the converter, predicted per accepted value
   class digit_scoreboard;
      typedef struct {
         logic [bda_pkg::DIGIT_W-1:0] digit_char;
         logic                        last;
      } digit_type;

      digit_type expected_digits[$];
      int        errors;

      function new();
         errors = 0;
      endfunction

      // Split one value into ASCII digits, most significant first
      function void note_value(logic [bda_pkg::VALUE_W-1:0] value);
         logic [bda_pkg::BCD_W-1:0] digs [bda_pkg::DEF_MAX_DIGITS];
         longint unsigned  rem;
         longint unsigned  limit;
         int               n;
         digit_type        item;
         limit = 1;
         for (int i = 0; i < bda_pkg::DEF_MAX_DIGITS; i++) limit = limit * 10;
         rem = value % limit;
         n = 0;
         // at least one digit, so zero gives a single '0'
         do begin
            digs[n] = bda_pkg::BCD_W'(rem % 10);
            rem = rem / 10;
            n++;
         end while (rem != 0 && n < bda_pkg::DEF_MAX_DIGITS);
         for (int k = 0; k < n; k++) begin
            item.digit_char = bda_pkg::ASCII_ZERO + bda_pkg::DIGIT_W'(digs[n - 1 - k]);
            item.last       = (k == n - 1);
            expected_digits = {expected_digits, item};
         end
      endfunction

      // Compare one accepted digit against the oldest expectation
      function void check_digit(logic [bda_pkg::DIGIT_W-1:0] digit_char, logic last);
         digit_type exp_item;
         if (expected_digits.size() == 0) begin
            $display("%0t: unexpected digit, expected none, actual char %0d last %0b",
                     $time, digit_char, last);
            errors++;
            return;
         end
         exp_item = expected_digits.pop_front();
         if (digit_char !== exp_item.digit_char) begin
            $display("%0t: digit_char mismatch, expected %0d actual %0d",
                     $time, exp_item.digit_char, digit_char);
            errors++;
         end
         if (last !== exp_item.last) begin
            $display("%0t: last mismatch, expected %0b actual %0b",
                     $time, exp_item.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_digits.size();
      endfunction
   endclass

   localparam int NUM_RANDOM   = 204;
   localparam int QUIET_TAIL   = 40;
   localparam int LONG_HOLD    = 200;
   localparam int END_SETTLE   = 40;

   logic clock;
   logic reset;

   bda_req_if req_bus ();
   bda_rsp_if rsp_bus ();

   binary_to_decimal_ascii_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   digit_scoreboard sb;

   // Receiver control, written by the stimulus process only
   bit rx_idle_on;
   bit hold_go;

   // Receiver state, owned by the receiver process
   bit hold_go_q;
   int hold_left;
   int stall_left;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Global watchdog
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Result side: check each transaction, then decide next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_go_q  = 1'b0;
         hold_left  = 0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_digit(rsp_bus.digit_char, rsp_bus.last);
         if (hold_go && !hold_go_q) hold_left = LONG_HOLD;
         hold_go_q = hold_go;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Offer one value, optionally after an idle burst; returns at acceptance
   task automatic send_value(input logic [bda_pkg::VALUE_W-1:0] value, input bit may_idle);
      int gap;
      gap = 0;
      if (may_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.value <= value;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_value(value);
   endtask

   // Stop offering until every predicted digit has come out
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Random value, spread over all digit counts with some raw 31-bit words
   function automatic logic [bda_pkg::VALUE_W-1:0] pick_value();
      int              nd;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned p;
      longint unsigned r;
      if ($urandom_range(0, 3) == 0) return bda_pkg::VALUE_W'($urandom);
      nd = $urandom_range(1, bda_pkg::DEF_MAX_DIGITS);
      p = 1;
      repeat (nd - 1) p = p * 10;
      lo = (nd == 1) ? 0 : p;
      hi = p * 10 - 1;
      if (hi > 64'd2147483647) hi = 64'd2147483647;
      r = {$urandom, $urandom};
      return bda_pkg::VALUE_W'(lo + r % (hi - lo + 1));
   endfunction

   // Stimulus
   initial begin
      logic [bda_pkg::VALUE_W-1:0] directed [$];
      longint unsigned    pw;
      sb = new();
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.value = '0;
      rx_idle_on    = 1'b1;
      hold_go       = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero, single digits, powers of ten and their neighbors, extremes
      directed = '{0, 1, 9, 10, 11, 99};
      pw = 100;
      for (int i = 2; i < bda_pkg::DEF_MAX_DIGITS; i++) begin
         directed = {directed, bda_pkg::VALUE_W'(pw)};
         directed = {directed, bda_pkg::VALUE_W'(pw - 1)};
         pw = pw * 10;
      end
      directed = {directed, 31'h7FFF_FFFF};
      directed = {directed, 31'h5555_5555};
      directed = {directed, 31'h2AAA_AAAA};
      directed = {directed, 31'h4000_0000};
      foreach (directed[i]) send_value(directed[i], 1'b1);
      drain_results();

      // Random part with a long receiver hold and a full drain along the way
      for (int i = 0; i < NUM_RANDOM; i++) begin
         if (i == 60) hold_go <= 1'b1;
         if (i == 90) hold_go <= 1'b0;
         if (i == 120) drain_results();
         if (i == NUM_RANDOM - QUIET_TAIL) rx_idle_on <= 1'b0;
         send_value(pick_value(), i < NUM_RANDOM - QUIET_TAIL);
      end
      req_bus.valid <= 1'b0;

      // Wait for the tail, then give the block time to show stray digits
      do @(posedge clock); while (sb.pending() != 0);
      repeat (END_SETTLE) @(posedge clock);

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
